### design/hkrb_pkg.sv
// Shared types and constants for the HID keyboard report builder.
package hkrb_pkg;

  localparam logic [7:0] ModFirst    = 8'hE0;
  localparam logic [7:0] ModLast     = 8'hE7;
  localparam logic [7:0] EmptyCode   = 8'h00;
  localparam int         ReportSlots = 6;

  typedef struct packed {
    logic [7:0] scancode;
    logic       key_down;
  } key_event_t;

  typedef struct packed {
    logic [7:0] modifier_byte;
    logic [7:0] slot0;
    logic [7:0] slot1;
    logic [7:0] slot2;
    logic [7:0] slot3;
    logic [7:0] slot4;
    logic [7:0] slot5;
    logic       last_report;
  } report_t;

endpackage

### design/hkrb_slot_update.sv
// Key slot next-state logic: insert on press, clear on release, pack to front.
module hkrb_slot_update #(
  parameter int SlotCount = 6
) (
  input  logic [SlotCount-1:0][7:0] slots_i,
  input  logic [7:0]                code_i,
  input  logic                      pressed_i,
  input  logic                      is_mod_i,
  output logic [SlotCount-1:0][7:0] upd_slots_o,
  output logic [SlotCount-1:0][7:0] next_slots_o
);

  localparam int CntW = $clog2(SlotCount + 1);

  logic [SlotCount-1:0]           empty;
  logic [SlotCount-1:0]           first_empty;
  logic [SlotCount-1:0]           nz;
  logic [SlotCount-1:0][CntW-1:0] rank;
  logic [SlotCount-1:0][7:0]      packed_slots;

  always_comb begin
    for (int i = 0; i < SlotCount; i++) begin
      empty[i] = (slots_i[i] == hkrb_pkg::EmptyCode);
    end
    // isolate lowest empty slot
    first_empty = empty & (~empty + SlotCount'(1));

    for (int i = 0; i < SlotCount; i++) begin
      if (is_mod_i) begin
        upd_slots_o[i] = slots_i[i];
      end else if (pressed_i) begin
        upd_slots_o[i] = first_empty[i] ? code_i : slots_i[i];
      end else begin
        upd_slots_o[i] = (slots_i[i] == code_i) ? hkrb_pkg::EmptyCode : slots_i[i];
      end
      nz[i] = (upd_slots_o[i] != hkrb_pkg::EmptyCode);
    end

    for (int i = 0; i < SlotCount; i++) begin
      rank[i] = '0;
      for (int k = 0; k < i; k++) begin
        rank[i] = rank[i] + CntW'(nz[k]);
      end
    end

    for (int j = 0; j < SlotCount; j++) begin
      packed_slots[j] = hkrb_pkg::EmptyCode;
      for (int i = 0; i < SlotCount; i++) begin
        if (nz[i] && (rank[i] == CntW'(j))) begin
          packed_slots[j] = packed_slots[j] | upd_slots_o[i];
        end
      end
    end

    next_slots_o = pressed_i ? upd_slots_o : packed_slots;
  end

endmodule

### design/hid_keyboard_report_builder_core.sv
// Top level of the HID boot keyboard report builder (modifiers and key slots).
//
//   channel | valid      | ready      | word
//   --------+------------+------------+----------------------------
//   in      | in_valid_i | in_ready_o | in_word_i  (key_event_t)
//   out     | out_valid_o| out_ready_i| out_word_o (report_t)
//
// A press yields one report; a release yields two reports,
// the cleared report then the packed report, both through the single output register.
// Reset empties all slots and clears the modifier byte.
// The input is taken whenever the output register is free or being drained and
// no packed report is pending; out stalls hold the report and back up into in.
module hid_keyboard_report_builder_core #(
  parameter int SlotCount = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hkrb_pkg::key_event_t in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hkrb_pkg::report_t    out_word_o
);

  logic [SlotCount-1:0][7:0] slots_q, slots_d;
  logic [SlotCount-1:0][7:0] upd_slots;
  logic [SlotCount-1:0][7:0] src_slots;
  logic [hkrb_pkg::ReportSlots-1:0][7:0] rpt_slots;
  logic [7:0]                mod_q, mod_d, mod_src;
  logic                      is_mod;
  logic                      pend_q;
  logic                      out_valid_q;
  hkrb_pkg::report_t         out_q, rpt;
  logic                      in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;

  assign in_ready_o  = !pend_q && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign is_mod = (in_word_i.scancode >= hkrb_pkg::ModFirst) &&
                  (in_word_i.scancode <= hkrb_pkg::ModLast);

  always_comb begin
    mod_d = mod_q;
    if (is_mod) begin
      mod_d[in_word_i.scancode[2:0]] = in_word_i.key_down;
    end
  end

  hkrb_slot_update #(
    .SlotCount(SlotCount)
  ) u_slot_update (
    .slots_i     (slots_q),
    .code_i      (in_word_i.scancode),
    .pressed_i   (in_word_i.key_down),
    .is_mod_i    (is_mod),
    .upd_slots_o (upd_slots),
    .next_slots_o(slots_d)
  );

  // pending packed report comes from the stored state
  assign src_slots = pend_q ? slots_q : upd_slots;
  assign mod_src   = pend_q ? mod_q : mod_d;

  for (genvar j = 0; j < hkrb_pkg::ReportSlots; j++) begin : g_rpt
    if (j < SlotCount) begin : g_used
      assign rpt_slots[j] = src_slots[j];
    end else begin : g_unused
      assign rpt_slots[j] = hkrb_pkg::EmptyCode;
    end
  end

  always_comb begin
    rpt.modifier_byte = mod_src;
    rpt.slot0         = rpt_slots[0];
    rpt.slot1         = rpt_slots[1];
    rpt.slot2         = rpt_slots[2];
    rpt.slot3         = rpt_slots[3];
    rpt.slot4         = rpt_slots[4];
    rpt.slot5         = rpt_slots[5];
    rpt.last_report   = pend_q ? 1'b1 : in_word_i.key_down;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= '0;
      mod_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      priority if (in_fire) begin
        slots_q     <= slots_d;
        mod_q       <= mod_d;
        pend_q      <= !in_word_i.key_down;
        out_valid_q <= 1'b1;
      end else if (out_fire && pend_q) begin
        pend_q <= 1'b0;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end else begin
        out_valid_q <= out_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire || (out_fire && pend_q)) begin
      out_q <= rpt;
    end
  end

endmodule

### dv/hkrb_report_check.sv
// Watches both channels of the report builder, predicts each report and compares it.
`timescale 1ns / 100ps

module hkrb_report_check #(
  parameter int SlotCount = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  hkrb_pkg::key_event_t in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  hkrb_pkg::report_t    out_word_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  logic [7:0]        mods_q;
  logic [7:0]        slots_q [SlotCount];
  hkrb_pkg::report_t reports_q [$];
  int                errors = 0;

  function automatic hkrb_pkg::report_t snapshot(input logic last);
    hkrb_pkg::report_t r;
    logic [7:0]        shown [hkrb_pkg::ReportSlots];
    for (int j = 0; j < hkrb_pkg::ReportSlots; j++) begin
      shown[j] = (j < SlotCount) ? slots_q[j] : hkrb_pkg::EmptyCode;
    end
    r.modifier_byte = mods_q;
    r.slot0 = shown[0];
    r.slot1 = shown[1];
    r.slot2 = shown[2];
    r.slot3 = shown[3];
    r.slot4 = shown[4];
    r.slot5 = shown[5];
    r.last_report = last;
    return r;
  endfunction

  task automatic apply_key(input hkrb_pkg::key_event_t ev);
    int   wr;
    logic placed;
    placed = 1'b0;
    if (ev.scancode >= hkrb_pkg::ModFirst && ev.scancode <= hkrb_pkg::ModLast) begin
      if (ev.key_down) begin
        mods_q = mods_q | (8'h01 << (ev.scancode - hkrb_pkg::ModFirst));
      end else begin
        mods_q = mods_q & ~(8'h01 << (ev.scancode - hkrb_pkg::ModFirst));
      end
    end else if (ev.key_down) begin
      for (int i = 0; i < SlotCount; i++) begin
        if (!placed && slots_q[i] == hkrb_pkg::EmptyCode) begin
          slots_q[i] = ev.scancode;
          placed = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < SlotCount; i++) begin
        if (slots_q[i] == ev.scancode) slots_q[i] = hkrb_pkg::EmptyCode;
      end
    end
    if (ev.key_down) begin
      reports_q.push_back(snapshot(1'b1));
    end else begin
      reports_q.push_back(snapshot(1'b0));
      // release: pack the held codes to the front
      wr = 0;
      for (int rd = 0; rd < SlotCount; rd++) begin
        if (slots_q[rd] != hkrb_pkg::EmptyCode) begin
          slots_q[wr] = slots_q[rd];
          wr++;
        end
      end
      for (int k = wr; k < SlotCount; k++) slots_q[k] = hkrb_pkg::EmptyCode;
      reports_q.push_back(snapshot(1'b1));
    end
  endtask

  task automatic flag(input string what, input logic [7:0] want, input logic [7:0] got);
    errors++;
    if (errors <= 10) $display("report mismatch on %s: expected %02h got %02h", what, want, got);
  endtask

  task automatic compare_report(input hkrb_pkg::report_t want, input hkrb_pkg::report_t got);
    if (got.modifier_byte !== want.modifier_byte)
      flag("modifier_byte", want.modifier_byte, got.modifier_byte);
    if (got.slot0 !== want.slot0) flag("slot0", want.slot0, got.slot0);
    if (got.slot1 !== want.slot1) flag("slot1", want.slot1, got.slot1);
    if (got.slot2 !== want.slot2) flag("slot2", want.slot2, got.slot2);
    if (got.slot3 !== want.slot3) flag("slot3", want.slot3, got.slot3);
    if (got.slot4 !== want.slot4) flag("slot4", want.slot4, got.slot4);
    if (got.slot5 !== want.slot5) flag("slot5", want.slot5, got.slot5);
    if (got.last_report !== want.last_report)
      flag("last_report", {7'd0, want.last_report}, {7'd0, got.last_report});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q = 8'h00;
      for (int i = 0; i < SlotCount; i++) slots_q[i] = hkrb_pkg::EmptyCode;
      reports_q.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      // output first: a word leaving now was caused by an earlier input word
      if (out_valid_i && out_ready_i) begin
        if (reports_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected report word %h", out_word_i);
        end else begin
          compare_report(reports_q.pop_front(), out_word_i);
        end
      end
      if (in_valid_i && in_ready_i) apply_key(in_word_i);
      pending_o    <= reports_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

### dv/hid_keyboard_report_builder_core_tb.sv
// Testbench top: drives key events and report backpressure, and gives the verdict.
`timescale 1ns / 100ps

module hid_keyboard_report_builder_core_tb;

  localparam int RandomItems = 750;
  localparam int HoldCycles  = 150;
  localparam int CycleLimit  = 200000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  hkrb_pkg::key_event_t in_word;
  logic                 out_valid;
  logic                 out_ready;
  hkrb_pkg::report_t    out_word;
  int                   fail_count;
  int                   pending;

  logic calm      = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  hid_keyboard_report_builder_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  hkrb_report_check u_report_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  function automatic hkrb_pkg::key_event_t ke(input logic [7:0] code, input logic down);
    hkrb_pkg::key_event_t ev;
    ev.scancode = code;
    ev.key_down = down;
    return ev;
  endfunction

  function automatic hkrb_pkg::key_event_t pick_event(input logic [7:0] base);
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return ke(base + 8'($urandom_range(7)), 1'b1);
    if (roll < 75) return ke(base + 8'($urandom_range(7)), 1'b0);
    if (roll < 87) return ke(hkrb_pkg::ModFirst + 8'($urandom_range(7)), 1'($urandom_range(1)));
    return ke(8'($urandom), 1'($urandom_range(1)));
  endfunction

  task automatic offer(input hkrb_pkg::key_event_t ev);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= ev;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  initial begin
    hkrb_pkg::key_event_t warmup [$];
    logic [7:0]           base;
    in_valid = 1'b0;
    in_word  = '0;
    rst_n    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill, zero code, duplicate, full drop, modifiers, neighbors of the modifier range
    warmup = '{ke(8'h04, 1'b1), ke(8'h05, 1'b1), ke(hkrb_pkg::EmptyCode, 1'b1),
               ke(hkrb_pkg::EmptyCode, 1'b0),
               ke(8'hFF, 1'b1), ke(8'h04, 1'b1), ke(8'h06, 1'b1), ke(8'h07, 1'b1),
               ke(8'h08, 1'b1), ke(hkrb_pkg::ModFirst, 1'b1), ke(hkrb_pkg::ModLast, 1'b1),
               ke(8'h04, 1'b0),
               ke(hkrb_pkg::ModFirst, 1'b0), ke(hkrb_pkg::ModLast, 1'b0), ke(8'hDF, 1'b1),
               ke(8'hE8, 1'b1),
               ke(8'hFF, 1'b0), ke(8'h05, 1'b0), ke(8'hDF, 1'b0), ke(8'h06, 1'b0),
               ke(8'h07, 1'b0), ke(8'hE8, 1'b0), ke(8'h09, 1'b0), ke(8'hE3, 1'b1),
               ke(8'hE3, 1'b0)};
    foreach (warmup[i]) offer(warmup[i]);

    hold_req = 1'b1;
    base = 8'h04;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 64 == 63) base = 8'($urandom_range(8'hD8, 1));
      calm = (n >= 300 && n < 450);
      offer(pick_event(base));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
